FILE: rtl/mse_pkg.sv
// Shared types, opcodes and status codes of the MIPS subset execute unit.
package mse_pkg;

   localparam int REG_COUNT = 32;

   typedef logic [31:0] word_type;
   typedef logic [4:0]  reg_idx_type;
   typedef logic [1:0]  status_type;
   typedef logic [1:0]  func_type;
   typedef logic [5:0]  opcode_type;

   localparam func_type FUNC_EXEC       = 2'd0;
   localparam func_type FUNC_PRESET_REG = 2'd1;
   localparam func_type FUNC_PRESET_MEM = 2'd2;

   localparam opcode_type OP_RTYPE = 6'd0;
   localparam opcode_type OP_BEQ   = 6'd4;
   localparam opcode_type OP_BNE   = 6'd5;
   localparam opcode_type OP_ADDI  = 6'd8;
   localparam opcode_type OP_LW    = 6'd35;
   localparam opcode_type OP_SW    = 6'd43;

   localparam opcode_type FN_ADD = 6'd32;
   localparam opcode_type FN_SUB = 6'd34;
   localparam opcode_type FN_SLT = 6'd42;

   localparam status_type ST_OK          = 2'd0;
   localparam status_type ST_UNSUPPORTED = 2'd1;
   localparam status_type ST_BAD_ADDR    = 2'd2;

   typedef struct packed {
      func_type    func;
      word_type    instruction;
      reg_idx_type preset_register;
      word_type    preset_address;
      word_type    preset_value;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic        reg_written;
      reg_idx_type reg_number;
      word_type    reg_value;
      logic        mem_written;
      word_type    mem_address;
      word_type    mem_value;
      logic        branch_taken;
      logic [15:0] branch_offset;
      logic        load;
   } exec_result_type;

   typedef struct packed {
      logic        valid;
      reg_idx_type num;
      word_type    value;
   } wb_type;

endpackage

FILE: rtl/mse_req_if.sv
// Request channel carrying one instruction or preset item per transfer.
interface mse_req_if;
   import mse_pkg::*;

   logic               valid;
   logic               ready;
   func_type           func;
   word_type           instruction;
   reg_idx_type        preset_register;
   word_type           preset_address;
   logic signed [31:0] preset_value;

   modport source (output valid, func, instruction, preset_register, preset_address,
                   preset_value, input ready);
   modport sink (input valid, func, instruction, preset_register, preset_address,
                 preset_value, output ready);
endinterface

FILE: rtl/mse_rsp_if.sv
// Response channel carrying one execution result per transfer.
interface mse_rsp_if;
   import mse_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   logic               reg_written;
   reg_idx_type        reg_number;
   logic signed [31:0] reg_value;
   logic               mem_written;
   word_type           mem_address;
   logic signed [31:0] mem_value;
   logic               branch_taken;
   logic signed [15:0] branch_offset;

   modport source (output valid, status, reg_written, reg_number, reg_value, mem_written,
                   mem_address, mem_value, branch_taken, branch_offset, input ready);
   modport sink (input valid, status, reg_written, reg_number, reg_value, mem_written,
                 mem_address, mem_value, branch_taken, branch_offset, output ready);
endinterface

FILE: rtl/mse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/mse_regfile.sv
// Register file with two read ports, reset-valid bits and write-back bypass.
module mse_regfile (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  mse_pkg::reg_idx_type   rd_addr_a,
   input  mse_pkg::reg_idx_type   rd_addr_b,
   input  mse_pkg::wb_type        wb,
   input  logic                   wb_commit,
   output mse_pkg::word_type      oper_a,
   output mse_pkg::word_type      oper_b
);
   import mse_pkg::*;

   logic                 wr_en;
   word_type             ram_a;
   word_type             ram_b;
   logic [REG_COUNT-1:0] vld_ff;
   reg_idx_type          rs_ff;
   reg_idx_type          rt_ff;
   logic                 a_fwd_ff;
   logic                 b_fwd_ff;
   word_type             a_fix_ff;
   word_type             b_fix_ff;
   word_type             base_a;
   word_type             base_b;

   assign wr_en = wb.valid && wb_commit;

   mse_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wb.num),
      .wr_data (wb.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_a),
      .rd_data (ram_a)
   );

   mse_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wb.num),
      .wr_data (wb.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_b),
      .rd_data (ram_b)
   );

   // A write that lands after the read was issued is captured here instead.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         a_fwd_ff <= 1'b0;
         b_fwd_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wb.num] <= 1'b1;
         end
         if (rd_en) begin
            a_fwd_ff <= wr_en && (wb.num == rd_addr_a);
            b_fwd_ff <= wr_en && (wb.num == rd_addr_b);
         end else begin
            if (wr_en && (wb.num == rs_ff)) begin
               a_fwd_ff <= 1'b1;
            end
            if (wr_en && (wb.num == rt_ff)) begin
               b_fwd_ff <= 1'b1;
            end
         end
      end
      if (rd_en) begin
         rs_ff    <= rd_addr_a;
         rt_ff    <= rd_addr_b;
         a_fix_ff <= wb.value;
         b_fix_ff <= wb.value;
      end else begin
         if (wr_en && (wb.num == rs_ff)) begin
            a_fix_ff <= wb.value;
         end
         if (wr_en && (wb.num == rt_ff)) begin
            b_fix_ff <= wb.value;
         end
      end
   end

   always_comb begin
      base_a = a_fwd_ff ? a_fix_ff : (vld_ff[rs_ff] ? ram_a : '0);
      base_b = b_fwd_ff ? b_fix_ff : (vld_ff[rt_ff] ? ram_b : '0);
      oper_a = (wb.valid && (wb.num == rs_ff)) ? wb.value : base_a;
      oper_b = (wb.valid && (wb.num == rt_ff)) ? wb.value : base_b;
   end
endmodule

FILE: rtl/mse_execute.sv
// Decode and execute logic for one item of the MIPS subset.
module mse_execute #(
   parameter int MEM_WORDS = 256
) (
   input  mse_pkg::req_item_type    item,
   input  mse_pkg::word_type        oper_a,
   input  mse_pkg::word_type        oper_b,
   output mse_pkg::exec_result_type res
);
   import mse_pkg::*;

   localparam logic [29:0] WORD_LIMIT = 30'(MEM_WORDS);

   opcode_type  op;
   opcode_type  fn;
   reg_idx_type rt;
   reg_idx_type rd;
   logic [15:0] imm;
   word_type    simm;
   word_type    sum_imm;
   logic        sum_ok;
   logic        preset_ok;
   logic        taken;

   always_comb begin
      op        = item.instruction[31:26];
      rt        = item.instruction[20:16];
      rd        = item.instruction[15:11];
      fn        = item.instruction[5:0];
      imm       = item.instruction[15:0];
      simm      = {{16{imm[15]}}, imm};
      sum_imm   = oper_a + simm;
      sum_ok    = (sum_imm[1:0] == 2'b00) && (sum_imm[31:2] < WORD_LIMIT);
      preset_ok = (item.preset_address[1:0] == 2'b00) &&
                  (item.preset_address[31:2] < WORD_LIMIT);
      taken     = (op == OP_BEQ) ? (oper_a == oper_b) : (oper_a != oper_b);
      res       = '0;

      case (item.func)
         FUNC_EXEC: begin
            case (op)
               OP_RTYPE: begin
                  res.reg_number = rd;
                  case (fn)
                     FN_ADD: res.reg_value = oper_a + oper_b;
                     FN_SUB: res.reg_value = oper_a - oper_b;
                     FN_SLT: res.reg_value = {31'd0, $signed(oper_a) < $signed(oper_b)};
                     default: res.status = ST_UNSUPPORTED;
                  endcase
                  res.reg_written = (res.status == ST_OK) && (rd != '0);
               end
               OP_LW: begin
                  res.mem_address = sum_imm;
                  if (!sum_ok) begin
                     res.status = ST_BAD_ADDR;
                  end else if (rt != '0) begin
                     res.reg_written = 1'b1;
                     res.reg_number  = rt;
                     res.load        = 1'b1;
                  end
               end
               OP_SW: begin
                  res.mem_address = sum_imm;
                  if (!sum_ok) begin
                     res.status = ST_BAD_ADDR;
                  end else begin
                     res.mem_written = 1'b1;
                     res.mem_value   = oper_b;
                  end
               end
               OP_ADDI: begin
                  res.reg_written = (rt != '0);
                  res.reg_number  = rt;
                  res.reg_value   = sum_imm;
               end
               OP_BEQ, OP_BNE: begin
                  if (taken) begin
                     res.branch_taken  = 1'b1;
                     res.branch_offset = imm;
                  end
               end
               default: res.status = ST_UNSUPPORTED;
            endcase
         end
         FUNC_PRESET_REG: begin
            res.reg_written = (item.preset_register != '0);
            res.reg_number  = item.preset_register;
            res.reg_value   = item.preset_value;
         end
         FUNC_PRESET_MEM: begin
            res.mem_address = item.preset_address;
            if (preset_ok) begin
               res.mem_written = 1'b1;
               res.mem_value   = item.preset_value;
            end else begin
               res.status = ST_BAD_ADDR;
            end
         end
         default: res.status = ST_UNSUPPORTED;
      endcase

      // Fields of a register write that did not happen read as zero.
      if (!res.reg_written) begin
         res.reg_number = '0;
         res.reg_value  = '0;
      end
   end
endmodule

FILE: rtl/mips_subset_execute_unit.sv
// Top level of the MIPS subset execute unit: pipeline, data memory and control.
//
// Items arrive on req_bus and results leave on rsp_bus, both valid/ready
// channels; a transfer happens at a rising edge where valid and ready are high.
// Each request item (an instruction, a register preset or a memory preset)
// yields exactly one result item, in order.
// The pipeline has three registered stages: operand read, execute and memory
// access, then the result register. An item passes through s1_ff, s2_ff and
// out_ff before it is offered; one item is taken per cycle while the receiver
// is ready and no clearing pass runs. Register writes of earlier items are
// forwarded and stores land before later loads read, so dependent instructions
// may follow each other in consecutive cycles. After reset the data memory is
// cleared one word per cycle; req_bus.ready stays low while that pass runs. The
// register file reads as zero after reset through per-register valid bits.
// When the receiver holds rsp_bus.ready low, the stages fill up and
// req_bus.ready drops once all three hold an item; nothing is lost.
module mips_subset_execute_unit #(
   parameter int MEM_WORDS = 256
) (
   input logic   clock,
   input logic   reset,
   mse_req_if.sink   req_bus,
   mse_rsp_if.source rsp_bus
);
   import mse_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);

   logic            accept;
   logic            out_free;
   logic            s2_free;
   logic            s2_adv;
   logic            s1_adv;
   logic            s1_valid_ff;
   logic            s1_valid_in;
   logic            s2_valid_ff;
   logic            s2_valid_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic            clearing_ff;
   logic            clearing_in;
   logic [AW-1:0]   clr_idx_ff;
   logic [AW-1:0]   clr_idx_in;
   req_item_type    req_item;
   req_item_type    s1_ff;
   exec_result_type exec_res;
   exec_result_type s2_ff;
   exec_result_type s2_done;
   exec_result_type out_ff;
   word_type        oper_a;
   word_type        oper_b;
   word_type        dmem_q;
   wb_type          wb;
   logic            dmem_wr_en;
   logic [AW-1:0]   dmem_wr_addr;
   word_type        dmem_wr_data;
   logic            dmem_rd_en;
   logic [AW-1:0]   dmem_idx;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign s2_adv   = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_adv   = s1_valid_ff && s2_free;
   assign req_bus.ready = (!s1_valid_ff || s2_free) && !clearing_ff;
   assign accept   = req_bus.valid && req_bus.ready;

   always_comb begin
      req_item.func            = req_bus.func;
      req_item.instruction     = req_bus.instruction;
      req_item.preset_register = req_bus.preset_register;
      req_item.preset_address  = req_bus.preset_address;
      req_item.preset_value    = req_bus.preset_value;
   end

   always_comb begin
      s2_done           = s2_ff;
      s2_done.reg_value = s2_ff.load ? dmem_q : s2_ff.reg_value;
      wb.valid          = s2_valid_ff && s2_ff.reg_written;
      wb.num            = s2_ff.reg_number;
      wb.value          = s2_done.reg_value;
   end

   mse_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_bus.instruction[25:21]),
      .rd_addr_b (req_bus.instruction[20:16]),
      .wb        (wb),
      .wb_commit (s2_adv),
      .oper_a    (oper_a),
      .oper_b    (oper_b)
   );

   mse_execute #(.MEM_WORDS(MEM_WORDS)) u_execute (
      .item   (s1_ff),
      .oper_a (oper_a),
      .oper_b (oper_b),
      .res    (exec_res)
   );

   always_comb begin
      dmem_idx   = exec_res.mem_address[AW+1:2];
      dmem_rd_en = s1_adv && exec_res.load;
      if (clearing_ff) begin
         dmem_wr_en   = 1'b1;
         dmem_wr_addr = clr_idx_ff;
         dmem_wr_data = '0;
      end else begin
         dmem_wr_en   = s1_adv && exec_res.mem_written;
         dmem_wr_addr = dmem_idx;
         dmem_wr_data = exec_res.mem_value;
      end
   end

   mse_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dmem_wr_en),
      .wr_addr (dmem_wr_addr),
      .wr_data (dmem_wr_data),
      .rd_en   (dmem_rd_en),
      .rd_addr (dmem_idx),
      .rd_data (dmem_q)
   );

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
      out_valid_in = s2_adv ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
      clearing_in  = clearing_ff && (clr_idx_ff != LAST_IDX);
      clr_idx_in   = clearing_ff ? AW'(clr_idx_ff + 1'b1) : clr_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         clearing_ff  <= clearing_in;
         clr_idx_ff   <= clr_idx_in;
      end
      if (accept) begin
         s1_ff <= req_item;
      end
      if (s1_adv) begin
         s2_ff <= exec_res;
      end
      if (s2_adv) begin
         out_ff <= s2_done;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.status        = out_ff.status;
   assign rsp_bus.reg_written   = out_ff.reg_written;
   assign rsp_bus.reg_number    = out_ff.reg_number;
   assign rsp_bus.reg_value     = out_ff.reg_value;
   assign rsp_bus.mem_written   = out_ff.mem_written;
   assign rsp_bus.mem_address   = out_ff.mem_address;
   assign rsp_bus.mem_value     = out_ff.mem_value;
   assign rsp_bus.branch_taken  = out_ff.branch_taken;
   assign rsp_bus.branch_offset = out_ff.branch_offset;

   a_no_item_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff && !s2_valid_ff)
      else $error("Item in flight during the memory clearing pass.");

   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.reg_written |-> out_ff.reg_number != '0)
      else $error("Result reports a write to register zero.");

   a_load_is_good: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_ff.load |-> s2_ff.status == ST_OK && s2_ff.reg_written)
      else $error("Load in the memory stage without a good register write.");

   a_offset_only_when_taken: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.branch_taken |-> out_ff.branch_offset == '0)
      else $error("Branch offset reported for a branch that was not taken.");
endmodule
